FILE: hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Request and result field widths
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_REMOVE_AT  = 3'd4;
    localparam t_op OP_MOVE_FRONT = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// request   in         i_in_valid / o_in_ready      i_operation, i_push_value, i_position
// result    out        o_out_valid / i_out_ready    o_removed_value, o_status, o_items_held,
//                                                   o_front_value, o_back_value
//
// One request at a time through a small sequencer around a single-port ring store.
// Push writes the new entry, pop reads the removed one; flagged or unused codes write nothing.
// Remove at and move to front shift entries, a read and a write each (one access a cycle).
// Reset empties the queue at once; store contents are not cleared.
// A waiting result holds the sequencer in its last state; a new request is taken once the
// sequencer is idle, even while an earlier result is still pending.

module bounded_double_ended_queue #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [bdq_pkg::OP_W-1:0]           i_operation,
    input  wire logic signed [bdq_pkg::WORD_W-1:0]  i_push_value,
    input  wire logic [bdq_pkg::POS_W-1:0]          i_position,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [bdq_pkg::WORD_W-1:0]       o_removed_value,
    output logic [bdq_pkg::STATUS_W-1:0]            o_status,
    output logic [bdq_pkg::COUNT_W-1:0]             o_items_held,
    output logic signed [bdq_pkg::WORD_W-1:0]       o_front_value,
    output logic signed [bdq_pkg::WORD_W-1:0]       o_back_value
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CNW = $clog2(CAPACITY + 1);
    localparam int XW  = CNW + 2;
    localparam int PCW = (CNW > bdq_pkg::POS_W) ? CNW : bdq_pkg::POS_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FETCH    = 4'd1;
    localparam logic [3:0] S_GRAB     = 4'd2;
    localparam logic [3:0] S_SHIFT_RD = 4'd3;
    localparam logic [3:0] S_SHIFT_WR = 4'd4;
    localparam logic [3:0] S_PLACE    = 4'd5;
    localparam logic [3:0] S_RD_FRONT = 4'd6;
    localparam logic [3:0] S_RD_BACK  = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    function automatic logic [bdq_pkg::WORD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] w);
        logic [63:0] ext;
        ext = 64'($signed(w));
        return ext[bdq_pkg::WORD_W-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [3:0]                 r_state, n_state;
    bdq_pkg::t_op               r_op, n_op;
    logic [IW-1:0]              r_idx, n_idx;
    logic [DATA_WIDTH-1:0]      r_hold, n_hold;
    logic [IW-1:0]              r_front, n_front;
    logic [CNW-1:0]             r_count, n_count;
    logic [DATA_WIDTH-1:0]      r_removed, n_removed;
    bdq_pkg::t_status           r_status, n_status;
    logic [DATA_WIDTH-1:0]      r_front_val, n_front_val;

    logic                               r_out_valid, n_out_valid;
    logic [bdq_pkg::WORD_W-1:0]         r_out_removed, n_out_removed;
    bdq_pkg::t_status                   r_out_status, n_out_status;
    logic [bdq_pkg::COUNT_W-1:0]        r_out_items, n_out_items;
    logic [bdq_pkg::WORD_W-1:0]         r_out_front, n_out_front;
    logic [bdq_pkg::WORD_W-1:0]         r_out_back, n_out_back;

    // shared ring address unit
    logic [IW-1:0]   slot_ofs;
    logic [IW:0]     slot_sum;
    logic [IW-1:0]   slot_addr;
    logic            rd_en;
    logic            wr_en;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [PCW-1:0]  pos_ext;
    logic [63:0]     push_ext;
    logic [IW-1:0]   last_idx;
    logic            out_free;

    assign pos_ext  = PCW'(i_position);
    assign push_ext = 64'(i_push_value);
    assign last_idx = IW'(r_count - CNW'(1));
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        slot_ofs = r_idx;
        if (r_state == S_SHIFT_RD) begin
            slot_ofs = (r_op == bdq_pkg::OP_REMOVE_AT) ? r_idx + IW'(1) : r_idx - IW'(1);
        end else if (r_state == S_RD_FRONT) begin
            slot_ofs = '0;
        end else if (r_state == S_RD_BACK) begin
            slot_ofs = last_idx;
        end
        slot_sum = {1'b0, r_front} + {1'b0, slot_ofs};
        if (slot_sum >= (IW+1)'(CAPACITY)) begin
            slot_sum = slot_sum - (IW+1)'(CAPACITY);
        end
        slot_addr = slot_sum[IW-1:0];
    end

    assign rd_en   = (r_state == S_FETCH) || (r_state == S_SHIFT_RD) ||
                     (r_state == S_RD_FRONT) || (r_state == S_RD_BACK);
    assign wr_en   = (r_state == S_SHIFT_WR) || (r_state == S_PLACE);
    assign wr_data = (r_state == S_SHIFT_WR) ? r_rd_data : r_hold;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[slot_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[slot_addr];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_idx         = r_idx;
        n_hold        = r_hold;
        n_front       = r_front;
        n_count       = r_count;
        n_removed     = r_removed;
        n_status      = r_status;
        n_front_val   = r_front_val;
        n_out_valid   = r_out_valid;
        n_out_removed = r_out_removed;
        n_out_status  = r_out_status;
        n_out_items   = r_out_items;
        n_out_front   = r_out_front;
        n_out_back    = r_out_back;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_operation;
                    n_removed = '0;
                    n_status  = bdq_pkg::ST_OK;
                    n_hold    = push_ext[DATA_WIDTH-1:0];
                    n_state   = S_RD_FRONT;
                    case (i_operation) inside
                        bdq_pkg::OP_PUSH_FRONT: begin
                            if (r_count == CNW'(CAPACITY)) begin
                                n_status = bdq_pkg::ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? IW'(CAPACITY - 1)
                                                          : r_front - IW'(1);
                                n_count = r_count + CNW'(1);
                                n_idx   = '0;
                                n_state = S_PLACE;
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK: begin
                            if (r_count == CNW'(CAPACITY)) begin
                                n_status = bdq_pkg::ST_FULL;
                            end else begin
                                n_idx   = IW'(r_count);
                                n_count = r_count + CNW'(1);
                                n_state = S_PLACE;
                            end
                        end
                        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = (i_operation == bdq_pkg::OP_POP_FRONT) ? '0 : last_idx;
                                n_state = S_FETCH;
                            end
                        end
                        bdq_pkg::OP_REMOVE_AT, bdq_pkg::OP_MOVE_FRONT: begin
                            if (pos_ext >= PCW'(r_count)) begin
                                n_status = bdq_pkg::ST_RANGE;
                            end else begin
                                n_idx   = pos_ext[IW-1:0];
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            // unused codes leave the queue alone
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state = S_GRAB;
            end
            S_GRAB: begin
                n_hold  = r_rd_data;
                n_state = S_RD_FRONT;
                case (r_op)
                    bdq_pkg::OP_POP_FRONT: begin
                        n_removed = r_rd_data;
                        n_front   = (r_front == IW'(CAPACITY - 1)) ? '0 : r_front + IW'(1);
                        n_count   = r_count - CNW'(1);
                    end
                    bdq_pkg::OP_POP_BACK: begin
                        n_removed = r_rd_data;
                        n_count   = r_count - CNW'(1);
                    end
                    bdq_pkg::OP_REMOVE_AT: begin
                        n_removed = r_rd_data;
                        if (XW'(r_idx) + XW'(1) < XW'(r_count)) begin
                            n_state = S_SHIFT_RD;
                        end else begin
                            n_count = r_count - CNW'(1);
                        end
                    end
                    default: begin
                        // move to front
                        n_state = (r_idx != '0) ? S_SHIFT_RD : S_PLACE;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                if (r_op == bdq_pkg::OP_REMOVE_AT) begin
                    n_idx = r_idx + IW'(1);
                    if (XW'(r_idx) + XW'(2) < XW'(r_count)) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_count = r_count - CNW'(1);
                        n_state = S_RD_FRONT;
                    end
                end else begin
                    n_idx   = r_idx - IW'(1);
                    n_state = (r_idx > IW'(1)) ? S_SHIFT_RD : S_PLACE;
                end
            end
            S_PLACE: begin
                n_state = S_RD_FRONT;
            end
            S_RD_FRONT: begin
                n_state = (r_count == '0) ? S_DONE : S_RD_BACK;
            end
            S_RD_BACK: begin
                n_front_val = r_rd_data;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_removed = to_field(r_removed);
                    n_out_status  = r_status;
                    n_out_items   = bdq_pkg::COUNT_W'(r_count);
                    if (r_count == '0) begin
                        n_out_front = '0;
                        n_out_back  = '0;
                    end else begin
                        n_out_front = to_field(r_front_val);
                        n_out_back  = to_field(r_rd_data);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_idx         <= n_idx;
        r_hold        <= n_hold;
        r_removed     <= n_removed;
        r_status      <= n_status;
        r_front_val   <= n_front_val;
        r_out_removed <= n_out_removed;
        r_out_status  <= n_out_status;
        r_out_items   <= n_out_items;
        r_out_front   <= n_out_front;
        r_out_back    <= n_out_back;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out_removed;
    assign o_status        = r_out_status;
    assign o_items_held    = r_out_items;
    assign o_front_value   = r_out_front;
    assign o_back_value    = r_out_back;

endmodule

`default_nettype wire
